FILE: hw/rtl/tsts_pkg.sv
// types and constants shared by the task table scheduler
`timescale 1ns / 1ps
package tsts_pkg;

	typedef enum logic [2:0] {
		CMD_CREATE    = 3'd0,
		CMD_DISPATCH  = 3'd1,
		CMD_YIELD     = 3'd2,
		CMD_SUSPEND   = 3'd3,
		CMD_WAKEUP    = 3'd4,
		CMD_TICK      = 3'd5,
		CMD_TERMINATE = 3'd6
	} cmd_t;

	typedef enum logic [2:0] {
		SS_UNUSED     = 3'd0,
		SS_RUNNABLE   = 3'd1,
		SS_RUNNING    = 3'd2,
		SS_WAITING    = 3'd3,
		SS_TERMINATED = 3'd4
	} slot_state_t;

	localparam logic [2:0] RS_OK       = 3'd0;
	localparam logic [2:0] RS_NONE     = 3'd1;
	localparam logic [2:0] RS_NO_TASK  = 3'd2;
	localparam logic [2:0] RS_TIMER    = 3'd3;
	localparam logic [2:0] RS_CPU_BUSY = 3'd4;

	localparam logic [15:0] DEFAULT_QUANTUM_RESET = 16'd10;

	// one task record as held in the table memory
	typedef struct packed {
		logic [31:0] id;
		logic [15:0] quantum;
		logic [7:0]  condition;
		logic [31:0] sleep;
		logic [31:0] exit_value;
	} task_rec_t;

endpackage

FILE: hw/rtl/tsts_req_if.sv
// request channel carrying one scheduler command
`timescale 1ns / 1ps
interface tsts_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [1:0]  cpu;
	logic [15:0] quantum;
	logic [7:0]  wait_cond;
	logic [31:0] sleep_count;
	logic signed [31:0] exit_value;

	modport source (output valid, cmd, cpu, quantum, wait_cond, sleep_count, exit_value,
		input ready);
	modport sink (input valid, cmd, cpu, quantum, wait_cond, sleep_count, exit_value,
		output ready);
endinterface

FILE: hw/rtl/tsts_rsp_if.sv
// result channel carrying one scheduler answer
`timescale 1ns / 1ps
interface tsts_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [3:0]  slot;
	logic [31:0] task_id;
	logic [15:0] slice;
	logic [31:0] tick_value;

	modport source (output valid, status, slot, task_id, slice, tick_value, input ready);
	modport sink (input valid, status, slot, task_id, slice, tick_value, output ready);
endinterface

FILE: hw/rtl/task_state_table_scheduler.sv
// create scans slot states one per cycle for a free slot; dispatch scans from the cpu's pointer
// and then reads the record; wakeup and tick read every record, tick writing back sleep counts;
// yield, suspend, terminate read the running record; refused or unknown commands go to the result.
// Throughput: one request at a time, set by the single-port record memory walk and a held result.
// Reset clears slot states, cpu state, counters and the result valid flag at once;
// the record memory is not cleared and no request waits on reset.
`timescale 1ns / 1ps
module task_state_table_scheduler
	import tsts_pkg::*;
#(
	parameter int TABLE_SLOTS = 16,
	parameter int CPU_COUNT   = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	tsts_req_if.sink    req,
	tsts_rsp_if.source  rsp
);

	localparam int SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int CW = SW + 1;
	localparam logic [SW-1:0] LAST_IDX = SW'(TABLE_SLOTS - 1);

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_RD,
		FSM_EV,
		FSM_DONE
	} fsm_t;

	fsm_t state_q;

	logic [15:0] dflt_q_q;
	slot_state_t slot_status_q [TABLE_SLOTS];
	logic        cpu_busy_q    [CPU_COUNT];
	logic [SW-1:0] cpu_run_q   [CPU_COUNT];
	logic [SW-1:0] cpu_scan_q  [CPU_COUNT];
	logic [31:0] last_id_q;
	logic [31:0] tick_q;

	// latched request
	logic [2:0]  cmd_q;
	logic [1:0]  cpu_q;
	logic [15:0] quantum_q;
	logic [7:0]  cond_q;
	logic [31:0] sleep_q;
	logic [31:0] exit_q;

	logic [SW-1:0] idx_q;
	logic [CW-1:0] cnt_q;

	// result being built
	logic [2:0]  res_status_q;
	logic [SW-1:0] res_slot_q;
	logic [31:0] res_id_q;
	logic [15:0] res_slice_q;
	logic        res_found_q;

	// result register
	logic        out_valid_q;
	logic [2:0]  out_status_q;
	logic [3:0]  out_slot_q;
	logic [31:0] out_id_q;
	logic [15:0] out_slice_q;
	logic [31:0] out_tick_q;

	// record memory
	task_rec_t   mem [TABLE_SLOTS];
	task_rec_t   rdata_q;
	logic        mem_we;
	task_rec_t   mem_wdata;

	logic          req_fire;
	logic          cpu_ok;
	logic          last;
	logic [SW-1:0] idx_next;

	assign req_fire = req.valid && req.ready;
	assign req.ready = (state_q == FSM_IDLE);
	assign cpu_ok = (32'(req.cpu) < 32'(CPU_COUNT));
	assign last = (cnt_q == CW'(TABLE_SLOTS - 1));
	assign idx_next = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.slot       = out_slot_q;
	assign rsp.task_id    = out_id_q;
	assign rsp.slice      = out_slice_q;
	assign rsp.tick_value = out_tick_q;

	// record write port
	always_comb begin
		mem_we = 1'b0;
		mem_wdata = rdata_q;
		case (state_q)
			FSM_SCAN: begin
				if (cmd_q == CMD_CREATE && slot_status_q[idx_q] == SS_UNUSED) begin
					mem_we = 1'b1;
					mem_wdata.id = last_id_q + 32'd1;
					mem_wdata.quantum = (quantum_q != '0) ? quantum_q : dflt_q_q;
					mem_wdata.condition = '0;
					mem_wdata.sleep = '0;
					mem_wdata.exit_value = '0;
				end
			end
			FSM_EV: begin
				case (cmd_q)
					CMD_SUSPEND: begin
						mem_we = 1'b1;
						mem_wdata.condition = cond_q;
						mem_wdata.sleep = sleep_q;
					end
					CMD_TERMINATE: begin
						mem_we = 1'b1;
						mem_wdata.exit_value = exit_q;
					end
					CMD_TICK: begin
						if (slot_status_q[idx_q] == SS_WAITING && rdata_q.sleep != '0
							&& rdata_q.condition == '0) begin
							mem_we = 1'b1;
							mem_wdata.sleep = rdata_q.sleep - 32'd1;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// memory with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[idx_q] <= mem_wdata;
		end
		rdata_q <= mem[idx_q];
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_q_q <= DEFAULT_QUANTUM_RESET;
		end else if (cfg_we) begin
			dflt_q_q <= cfg_wdata;
		end
	end

	// sequencer, slot and cpu state, result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			for (int i = 0; i < TABLE_SLOTS; i++) begin
				slot_status_q[i] <= SS_UNUSED;
			end
			for (int c = 0; c < CPU_COUNT; c++) begin
				cpu_busy_q[c] <= 1'b0;
				cpu_run_q[c] <= '0;
				cpu_scan_q[c] <= '0;
			end
			last_id_q <= '0;
			tick_q <= '0;
			out_valid_q <= 1'b0;
			cmd_q <= '0;
			cpu_q <= '0;
			idx_q <= '0;
			cnt_q <= '0;
			res_found_q <= 1'b0;
		end else begin
			// release the result unless a new one is loaded this cycle
			if (out_valid_q && rsp.ready && state_q != FSM_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				FSM_IDLE: begin
					if (req_fire) begin
						cmd_q <= req.cmd;
						cpu_q <= req.cpu;
						quantum_q <= req.quantum;
						cond_q <= req.wait_cond;
						sleep_q <= req.sleep_count;
						exit_q <= req.exit_value;
						cnt_q <= '0;
						idx_q <= '0;
						res_status_q <= RS_OK;
						res_slot_q <= '0;
						res_id_q <= '0;
						res_slice_q <= '0;
						res_found_q <= 1'b0;
						case (req.cmd)
							CMD_CREATE: state_q <= FSM_SCAN;
							CMD_DISPATCH: begin
								if (!cpu_ok || cpu_busy_q[req.cpu]) begin
									res_status_q <= RS_CPU_BUSY;
									state_q <= FSM_DONE;
								end else begin
									idx_q <= cpu_scan_q[req.cpu];
									state_q <= FSM_SCAN;
								end
							end
							CMD_YIELD, CMD_SUSPEND, CMD_TERMINATE: begin
								if (!cpu_ok || !cpu_busy_q[req.cpu]) begin
									res_status_q <= RS_NO_TASK;
									state_q <= FSM_DONE;
								end else begin
									idx_q <= cpu_run_q[req.cpu];
									state_q <= FSM_RD;
								end
							end
							CMD_WAKEUP: state_q <= FSM_RD;
							CMD_TICK: begin
								tick_q <= tick_q + 32'd1;
								state_q <= FSM_RD;
							end
							default: state_q <= FSM_DONE;
						endcase
					end
				end
				// status-only walk for create and dispatch
				FSM_SCAN: begin
					if (cmd_q == CMD_CREATE) begin
						if (slot_status_q[idx_q] == SS_UNUSED) begin
							last_id_q <= last_id_q + 32'd1;
							slot_status_q[idx_q] <= SS_RUNNABLE;
							res_slot_q <= idx_q;
							res_id_q <= last_id_q + 32'd1;
							state_q <= FSM_DONE;
						end else if (last) begin
							res_status_q <= RS_NONE;
							state_q <= FSM_DONE;
						end else begin
							idx_q <= idx_next;
							cnt_q <= cnt_q + 1'b1;
						end
					end else begin
						if (slot_status_q[idx_q] == SS_RUNNABLE) begin
							slot_status_q[idx_q] <= SS_RUNNING;
							cpu_busy_q[cpu_q] <= 1'b1;
							cpu_run_q[cpu_q] <= idx_q;
							cpu_scan_q[cpu_q] <= idx_next;
							res_slot_q <= idx_q;
							state_q <= FSM_RD;
						end else if (last) begin
							res_status_q <= RS_NONE;
							state_q <= FSM_DONE;
						end else begin
							idx_q <= idx_next;
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				FSM_RD: state_q <= FSM_EV;
				// act on the record just read
				FSM_EV: begin
					case (cmd_q)
						CMD_DISPATCH: begin
							res_id_q <= rdata_q.id;
							res_slice_q <= rdata_q.quantum;
							state_q <= FSM_DONE;
						end
						CMD_YIELD, CMD_SUSPEND, CMD_TERMINATE: begin
							res_slot_q <= idx_q;
							res_id_q <= rdata_q.id;
							cpu_busy_q[cpu_q] <= 1'b0;
							if (cmd_q == CMD_YIELD) begin
								slot_status_q[idx_q] <= SS_RUNNABLE;
							end else if (cmd_q == CMD_SUSPEND) begin
								slot_status_q[idx_q] <= SS_WAITING;
							end else begin
								slot_status_q[idx_q] <= SS_TERMINATED;
							end
							state_q <= FSM_DONE;
						end
						CMD_WAKEUP: begin
							if (slot_status_q[idx_q] == SS_WAITING
								&& rdata_q.condition == cond_q) begin
								slot_status_q[idx_q] <= SS_RUNNABLE;
								if (!res_found_q) begin
									res_found_q <= 1'b1;
									res_slot_q <= idx_q;
									res_id_q <= rdata_q.id;
								end
							end
							idx_q <= idx_next;
							cnt_q <= cnt_q + 1'b1;
							state_q <= last ? FSM_DONE : FSM_RD;
						end
						default: begin
							// tick
							if (slot_status_q[idx_q] == SS_WAITING && rdata_q.sleep != '0) begin
								if (rdata_q.condition != '0) begin
									if (!res_found_q) begin
										res_found_q <= 1'b1;
										res_status_q <= RS_TIMER;
										res_slot_q <= idx_q;
										res_id_q <= rdata_q.id;
									end
								end else if (rdata_q.sleep == 32'd1) begin
									slot_status_q[idx_q] <= SS_RUNNABLE;
								end
							end
							idx_q <= idx_next;
							cnt_q <= cnt_q + 1'b1;
							state_q <= last ? FSM_DONE : FSM_RD;
						end
					endcase
				end
				// hand the result over once the output register is free
				FSM_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						out_status_q <= res_status_q;
						out_slot_q <= 4'(res_slot_q);
						out_id_q <= res_id_q;
						out_slice_q <= res_slice_q;
						out_tick_q <= tick_q;
						state_q <= FSM_IDLE;
					end else begin
						out_valid_q <= 1'b1;
					end
				end
				default: state_q <= FSM_IDLE;
			endcase
		end
	end

endmodule

FILE: hw/rtl/tsts_checker.sv
// port-level checks for the task table scheduler and their binding
`timescale 1ns / 1ps
module tsts_checker
	import tsts_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] out_status
);

	// a held result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// only defined status codes leave the block
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_status == RS_OK || out_status == RS_NONE
			|| out_status == RS_NO_TASK || out_status == RS_TIMER
			|| out_status == RS_CPU_BUSY))
		else $error("undefined status code");

	// one request in work at a time
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	// no result right after reset
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result present after reset");

endmodule

bind task_state_table_scheduler tsts_checker u_tsts_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (req.valid),
	.in_ready   (req.ready),
	.out_valid  (rsp.valid),
	.out_ready  (rsp.ready),
	.out_status (rsp.status)
);

FILE: test/tb.sv
// testbench for the task table scheduler: directed table, then predictor-checked random requests
`timescale 1ns / 1ps
module tb;
	import tsts_pkg::*;

	localparam int SLOTS      = 16;
	localparam int CPUS       = 4;
	localparam int IDLE_WAIT  = 40;
	localparam int STALL_LIM  = 2000;
	localparam int LONG_HOLD  = 300;
	localparam logic [2:0] CMD_UNKNOWN = 3'd7;

	typedef struct {
		logic [2:0]  cmd;
		logic [1:0]  cpu;
		logic [15:0] quantum;
		logic [7:0]  wait_cond;
		logic [31:0] sleep_count;
		logic [31:0] exit_value;
	} sched_req_t;

	typedef struct {
		logic [2:0]  status;
		logic [3:0]  slot;
		logic [31:0] task_id;
		logic [15:0] slice;
		logic [31:0] tick_value;
	} sched_rsp_t;

	typedef struct {
		sched_req_t req;
		bit         typed;
		sched_rsp_t answer;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [15:0] cfg_wdata;

	tsts_req_if req_ch();
	tsts_rsp_if rsp_ch();

	task_state_table_scheduler #(.TABLE_SLOTS(SLOTS), .CPU_COUNT(CPUS)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// predictor state
	slot_state_t  tbl_state [SLOTS];
	logic [31:0]  tbl_id [SLOTS];
	logic [15:0]  tbl_quantum [SLOTS];
	logic [15:0]  tbl_slice [SLOTS];
	logic [7:0]   tbl_cond [SLOTS];
	logic [31:0]  tbl_sleep [SLOTS];
	logic [31:0]  tbl_exit [SLOTS];
	bit           cpu_busy [CPUS];
	logic [3:0]   cpu_task [CPUS];
	logic [3:0]   cpu_scan [CPUS];
	logic [31:0]  id_counter;
	logic [31:0]  tick_counter;
	logic [15:0]  quantum_default;

	sched_rsp_t expected_answers [$];
	int   fail_count;
	bit   long_hold_req;
	int   burst_left;

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic sched_rsp_t predict_schedule(input sched_req_t r);
		sched_rsp_t a;
		int s;
		bit found;
		a = '{default: '0};
		found = 0;
		case (r.cmd)
			CMD_CREATE: begin
				a.status = RS_NONE;
				for (int i = 0; i < SLOTS; i++) begin
					if (!found && tbl_state[i] == SS_UNUSED) begin
						found = 1;
						id_counter = id_counter + 32'd1;
						tbl_id[i] = id_counter;
						tbl_quantum[i] = (r.quantum != 0) ? r.quantum : quantum_default;
						tbl_cond[i] = '0;
						tbl_sleep[i] = '0;
						tbl_state[i] = SS_RUNNABLE;
						a.status = RS_OK;
						a.slot = 4'(i);
						a.task_id = id_counter;
					end
				end
			end
			CMD_DISPATCH: begin
				if (cpu_busy[r.cpu]) begin
					a.status = RS_CPU_BUSY;
				end else begin
					a.status = RS_NONE;
					for (int i = 0; i < SLOTS; i++) begin
						s = (int'(cpu_scan[r.cpu]) + i) % SLOTS;
						if (!found && tbl_state[s] == SS_RUNNABLE) begin
							found = 1;
							tbl_state[s] = SS_RUNNING;
							tbl_slice[s] = tbl_quantum[s];
							cpu_busy[r.cpu] = 1;
							cpu_task[r.cpu] = 4'(s);
							cpu_scan[r.cpu] = 4'((s + 1) % SLOTS);
							a.status = RS_OK;
							a.slot = 4'(s);
							a.task_id = tbl_id[s];
							a.slice = tbl_slice[s];
						end
					end
				end
			end
			CMD_YIELD, CMD_SUSPEND, CMD_TERMINATE: begin
				if (!cpu_busy[r.cpu]) begin
					a.status = RS_NO_TASK;
				end else begin
					s = int'(cpu_task[r.cpu]);
					a.slot = 4'(s);
					a.task_id = tbl_id[s];
					cpu_busy[r.cpu] = 0;
					if (r.cmd == CMD_YIELD) begin
						tbl_state[s] = SS_RUNNABLE;
					end else if (r.cmd == CMD_SUSPEND) begin
						tbl_cond[s] = r.wait_cond;
						tbl_sleep[s] = r.sleep_count;
						tbl_state[s] = SS_WAITING;
					end else begin
						tbl_exit[s] = r.exit_value;
						tbl_state[s] = SS_TERMINATED;
					end
				end
			end
			CMD_WAKEUP: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (tbl_state[i] == SS_WAITING && tbl_cond[i] == r.wait_cond) begin
						tbl_state[i] = SS_RUNNABLE;
						if (!found) begin
							found = 1;
							a.slot = 4'(i);
							a.task_id = tbl_id[i];
						end
					end
				end
			end
			CMD_TICK: begin
				tick_counter = tick_counter + 32'd1;
				for (int i = 0; i < SLOTS; i++) begin
					if (tbl_state[i] == SS_WAITING && tbl_sleep[i] != 0) begin
						if (tbl_cond[i] != 0) begin
							// timer mismatch, lowest slot reported
							if (a.status == RS_OK) begin
								a.status = RS_TIMER;
								a.slot = 4'(i);
								a.task_id = tbl_id[i];
							end
						end else begin
							tbl_sleep[i] = tbl_sleep[i] - 32'd1;
							if (tbl_sleep[i] == 0)
								tbl_state[i] = SS_RUNNABLE;
						end
					end
				end
			end
			default: ;
		endcase
		a.tick_value = tick_counter;
		return a;
	endfunction

	function automatic int count_state(input slot_state_t st);
		int n;
		n = 0;
		for (int i = 0; i < SLOTS; i++)
			if (tbl_state[i] == st)
				n++;
		return n;
	endfunction

	// one request through the handshake, then an optional gap
	task automatic send_request(input sched_req_t r, input bit typed, input sched_rsp_t typed_ans);
		sched_rsp_t a;
		int gap;
		req_ch.valid       <= 1'b1;
		req_ch.cmd         <= r.cmd;
		req_ch.cpu         <= r.cpu;
		req_ch.quantum     <= r.quantum;
		req_ch.wait_cond   <= r.wait_cond;
		req_ch.sleep_count <= r.sleep_count;
		req_ch.exit_value  <= r.exit_value;
		do @(posedge clk); while (!req_ch.ready);
		a = predict_schedule(r);
		expected_answers.push_back(typed ? typed_ans : a);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 6);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
				: $urandom_range(0, 8);
		end
	endtask

	task automatic drain_and_settle();
		req_ch.valid <= 1'b0;
		wait (expected_answers.size() == 0);
		repeat (IDLE_WAIT) @(posedge clk);
	endtask

	task automatic write_default_quantum(input logic [15:0] v);
		drain_and_settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		quantum_default = v;
	endtask

	function automatic sched_req_t random_request(input int create_cap, input bit allow_end);
		sched_req_t r;
		int pick;
		r.cpu         = 2'($urandom_range(0, 3));
		r.quantum     = ($urandom_range(0, 3) == 0) ? 16'd0 :
			16'(($urandom_range(0, 1) != 0) ? $urandom_range(1, 40) : $urandom);
		r.wait_cond   = 8'(($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 3));
		r.sleep_count = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 5);
		r.exit_value  = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 15)      r.cmd = CMD_CREATE;
		else if (pick < 40) r.cmd = CMD_DISPATCH;
		else if (pick < 52) r.cmd = CMD_YIELD;
		else if (pick < 64) r.cmd = CMD_SUSPEND;
		else if (pick < 75) r.cmd = CMD_WAKEUP;
		else if (pick < 90) r.cmd = CMD_TICK;
		else if (pick < 97) r.cmd = CMD_TERMINATE;
		else                r.cmd = CMD_UNKNOWN;
		// keep free slots for later phases and keep terminated tasks from taking over
		if (r.cmd == CMD_CREATE && SLOTS - count_state(SS_UNUSED) >= create_cap)
			r.cmd = CMD_DISPATCH;
		if (r.cmd == CMD_TERMINATE && !allow_end && count_state(SS_TERMINATED) >= 9)
			r.cmd = CMD_YIELD;
		return r;
	endfunction

	// result checking
	always @(posedge clk) begin
		sched_rsp_t e;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_answers.size() == 0) begin
				$error("result with no request outstanding: status %0d slot %0d",
					rsp_ch.status, rsp_ch.slot);
				fail_count++;
			end else begin
				e = expected_answers.pop_front();
				if (rsp_ch.status !== e.status) begin
					$error("status: expected %0d actual %0d", e.status, rsp_ch.status);
					fail_count++;
				end
				if (rsp_ch.slot !== e.slot) begin
					$error("slot: expected %0d actual %0d", e.slot, rsp_ch.slot);
					fail_count++;
				end
				if (rsp_ch.task_id !== e.task_id) begin
					$error("task_id: expected %0h actual %0h", e.task_id, rsp_ch.task_id);
					fail_count++;
				end
				if (rsp_ch.slice !== e.slice) begin
					$error("slice: expected %0d actual %0d", e.slice, rsp_ch.slice);
					fail_count++;
				end
				if (rsp_ch.tick_value !== e.tick_value) begin
					$error("tick_value: expected %0d actual %0d", e.tick_value,
						rsp_ch.tick_value);
					fail_count++;
				end
			end
		end
	end

	// receiver stall pattern, with a long hold-off on request
	initial begin
		int mode;
		int cnt;
		rsp_ch.ready = 1'b0;
		mode = 0;
		cnt = 0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold_req = 0;
			end else begin
				cnt++;
				if (cnt % 64 == 0)
					mode = $urandom_range(0, 2);
				case (mode)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= (cnt % 4) != 0;
					default: rsp_ch.ready <= 1'($urandom_range(0, 1));
				endcase
			end
		end
	end

	// watchdog on handshake progress
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIM) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// stimulus
	initial begin
		stim_row_t rows [$];
		sched_req_t r;
		sched_rsp_t none;
		int phase_items [4];
		int phase_caps [4];
		logic [15:0] phase_dq [4];

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.cmd = '0;
		req_ch.cpu = '0;
		req_ch.quantum = '0;
		req_ch.wait_cond = '0;
		req_ch.sleep_count = '0;
		req_ch.exit_value = '0;
		fail_count = 0;
		long_hold_req = 0;
		burst_left = 0;
		none = '{default: '0};

		for (int i = 0; i < SLOTS; i++) begin
			tbl_state[i] = SS_UNUSED;
			tbl_id[i] = '0;
			tbl_quantum[i] = '0;
			tbl_slice[i] = '0;
			tbl_cond[i] = '0;
			tbl_sleep[i] = '0;
			tbl_exit[i] = '0;
		end
		for (int c = 0; c < CPUS; c++) begin
			cpu_busy[c] = 0;
			cpu_task[c] = '0;
			cpu_scan[c] = '0;
		end
		id_counter = '0;
		tick_counter = '0;
		quantum_default = DEFAULT_QUANTUM_RESET;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: cmd, cpu, quantum, cond, sleep, exit, typed, answer
		rows.push_back('{'{CMD_DISPATCH, 2'd0, 16'd0, 8'd0, 32'd0, 32'd0}, 1,
			'{RS_NONE, 4'd0, 32'd0, 16'd0, 32'd0}});
		rows.push_back('{'{CMD_YIELD, 2'd1, 16'd0, 8'd0, 32'd0, 32'd0}, 1,
			'{RS_NO_TASK, 4'd0, 32'd0, 16'd0, 32'd0}});
		rows.push_back('{'{CMD_TICK, 2'd0, 16'd0, 8'd0, 32'd0, 32'd0}, 1,
			'{RS_OK, 4'd0, 32'd0, 16'd0, 32'd1}});
		rows.push_back('{'{CMD_CREATE, 2'd0, 16'd0, 8'd0, 32'd0, 32'd0}, 1,
			'{RS_OK, 4'd0, 32'd1, 16'd0, 32'd1}});
		rows.push_back('{'{CMD_CREATE, 2'd3, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1,
			'{RS_OK, 4'd1, 32'd2, 16'd0, 32'd1}});
		rows.push_back('{'{CMD_DISPATCH, 2'd0, 16'd0, 8'd0, 32'd0, 32'd0}, 0, none});
		rows.push_back('{'{CMD_DISPATCH, 2'd0, 16'd0, 8'd0, 32'd0, 32'd0}, 1,
			'{RS_CPU_BUSY, 4'd0, 32'd0, 16'd0, 32'd1}});
		rows.push_back('{'{CMD_DISPATCH, 2'd1, 16'd0, 8'd0, 32'd0, 32'd0}, 0, none});
		// sleep of zero ticks on the timer waits for a wakeup
		rows.push_back('{'{CMD_SUSPEND, 2'd0, 16'd0, 8'd0, 32'd0, 32'd0}, 0, none});
		rows.push_back('{'{CMD_TICK, 2'd0, 16'd0, 8'd0, 32'd0, 32'd0}, 0, none});
		rows.push_back('{'{CMD_WAKEUP, 2'd0, 16'd0, 8'd0, 32'd0, 32'd0}, 0, none});
		// timer mismatch on a non-timer waiter
		rows.push_back('{'{CMD_SUSPEND, 2'd1, 16'd0, 8'hFF, 32'hFFFF_FFFF, 32'd0}, 0, none});
		rows.push_back('{'{CMD_TICK, 2'd0, 16'd0, 8'd0, 32'd0, 32'd0}, 0, none});
		rows.push_back('{'{CMD_WAKEUP, 2'd0, 16'd0, 8'hFF, 32'd0, 32'd0}, 0, none});
		rows.push_back('{'{CMD_WAKEUP, 2'd0, 16'd0, 8'd77, 32'd0, 32'd0}, 0, none});
		rows.push_back('{'{CMD_DISPATCH, 2'd2, 16'd0, 8'd0, 32'd0, 32'd0}, 0, none});
		rows.push_back('{'{CMD_TERMINATE, 2'd2, 16'd0, 8'd0, 32'd0, 32'h8000_0000}, 0, none});
		rows.push_back('{'{CMD_DISPATCH, 2'd3, 16'd0, 8'd0, 32'd0, 32'd0}, 0, none});
		rows.push_back('{'{CMD_TERMINATE, 2'd3, 16'd0, 8'd0, 32'd0, 32'h7FFF_FFFF}, 0, none});
		rows.push_back('{'{CMD_UNKNOWN, 2'd3, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 0,
			none});
		rows.push_back('{'{CMD_CREATE, 2'd0, 16'd1, 8'd0, 32'd0, 32'd0}, 0, none});
		rows.push_back('{'{CMD_DISPATCH, 2'd0, 16'd0, 8'd0, 32'd0, 32'd0}, 0, none});
		rows.push_back('{'{CMD_SUSPEND, 2'd0, 16'd0, 8'd0, 32'd1, 32'd0}, 0, none});
		rows.push_back('{'{CMD_TICK, 2'd0, 16'd0, 8'd0, 32'd0, 32'd0}, 0, none});
		foreach (rows[k])
			send_request(rows[k].req, rows[k].typed, rows[k].answer);

		// random phases, each under its own default quantum
		phase_dq    = '{16'd0, 16'hFFFF, 16'd1, 16'd0};
		phase_dq[3] = 16'($urandom_range(1, 65535));
		phase_items = '{230, 230, 230, 230};
		phase_caps  = '{7, 11, 14, SLOTS};
		for (int p = 0; p < 4; p++) begin
			write_default_quantum(phase_dq[p]);
			if (p == 1)
				long_hold_req = 1;
			for (int n = 0; n < phase_items[p]; n++) begin
				if (p == 2 && n == 100)
					drain_and_settle();
				r = random_request(phase_caps[p], p == 3);
				send_request(r, 0, none);
			end
		end

		req_ch.valid <= 1'b0;
		wait (expected_answers.size() == 0);
		repeat (IDLE_WAIT) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/tsts_pkg.sv
hw/rtl/tsts_req_if.sv
hw/rtl/tsts_rsp_if.sv
hw/rtl/task_state_table_scheduler.sv
hw/rtl/tsts_checker.sv
test/tb.sv
